### rtl/rvdec_pkg.sv
// Shared types and constants for the RV32IMA decode stage.
// Holds opcodes, exception codes and the packed beat layouts used by the
// top level and its port checker. No dependencies.
package rvdec_pkg;

  // Major opcodes, insn[6:0]
  localparam logic [6:0] OPC_LUI     = 7'h37;
  localparam logic [6:0] OPC_AUIPC   = 7'h17;
  localparam logic [6:0] OPC_JAL     = 7'h6f;
  localparam logic [6:0] OPC_JALR    = 7'h67;
  localparam logic [6:0] OPC_BRANCH  = 7'h63;
  localparam logic [6:0] OPC_LOAD    = 7'h03;
  localparam logic [6:0] OPC_STORE   = 7'h23;
  localparam logic [6:0] OPC_OPIMM   = 7'h13;
  localparam logic [6:0] OPC_OP      = 7'h33;
  localparam logic [6:0] OPC_AMO     = 7'h2f;
  localparam logic [6:0] OPC_MISCMEM = 7'h0f;
  localparam logic [6:0] OPC_SYSTEM  = 7'h73;

  // Full words of the two environment calls
  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  // Exception codes, cause plus one
  localparam logic [4:0] EXC_NONE    = 5'd0;
  localparam logic [4:0] EXC_ILLEGAL = 5'd3;
  localparam logic [4:0] EXC_BREAK   = 5'd4;
  localparam logic [4:0] EXC_ECALL   = 5'd12;

  // funct7 values
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_MUL  = 7'h01;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // AMO funct5 of load-reserved
  localparam logic [4:0] AMO_LR = 5'h02;

  localparam int IN_BITS  = 120;
  localparam int OUT_BITS = 104;

  // Input beat, last field listed in the lowest bits
  typedef struct packed {
    logic [4:0]  pad;
    logic [4:0]  mem_rd;
    logic        mem_writes_rd;
    logic        mem_valid;
    logic [4:0]  ex_rd;
    logic        ex_writes_rd;
    logic        ex_valid;
    logic [31:0] in_tval;
    logic [4:0]  in_exception;
    logic [31:0] pc;
    logic [31:0] insn;
  } in_item_t;

  // Result beat, last field listed in the lowest bits
  typedef struct packed {
    logic [5:0]         pad;
    logic [31:0]        trap_value;
    logic [4:0]         exception_code;
    logic [11:0]        csr_number;
    logic signed [31:0] immediate;
    logic               writes_dest;
    logic [4:0]         src2_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         dest_reg;
    logic               stall_res;
  } out_item_t;

endpackage

### rtl/rv32ima_decode_with_hazard_stall.sv
// RV32IMA decode stage with EX/MEM hazard stall detection.
// Input register, combinational decode, result register. Uses rvdec_pkg.
//
//  channel | dir | beat contents
//  s_axis  | in  | insn, pc, in_exception, in_tval, EX and MEM destination status
//  m_axis  | out | register indices, writes flag, immediate, CSR, exception, stall
//
// One beat per clock unless m_axis stalls; registered at input and output.
// The decode is one pass of combinational logic between the two registers.
// rst clears both valid flags; payload registers are not reset.
// A stalled output holds its beat; one further beat waits in the input register.
module rv32ima_decode_with_hazard_stall
  import rvdec_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // low to high: insn, pc, in_exception, in_tval, ex_valid, ex_writes_rd, ex_rd,
  // mem_valid, mem_writes_rd, mem_rd, zero pad
  input  logic [IN_BITS-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // low to high: stall_res, dest_reg, src1_reg, src2_reg, writes_dest, immediate,
  // csr_number, exception_code, trap_value, zero pad
  output logic [OUT_BITS-1:0] m_axis_tdata
);

  logic      in_valid;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  logic      adv_out;
  out_item_t dec;

  assign adv_out       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || adv_out;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (adv_out) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= in_item_t'(s_axis_tdata);
    end
    if (adv_out && in_valid) begin
      out_item <= dec;
    end
  end

  // Decode
  logic [31:0] i;
  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rs1, rs2;
  logic [31:0] imm;
  logic [11:0] csr;
  logic        wr, use1, use2, legal;
  logic [4:0]  exc;
  logic [31:0] tval;
  logic        h1, h2;

  assign i   = in_item.insn;
  assign op  = i[6:0];
  assign f3  = i[14:12];
  assign f7  = i[31:25];
  assign rs1 = i[19:15];
  assign rs2 = i[24:20];

  always_comb begin
    imm   = '0;
    csr   = '0;
    wr    = 1'b0;
    use1  = 1'b0;
    use2  = 1'b0;
    legal = 1'b1;
    exc   = in_item.in_exception;
    tval  = in_item.in_tval;
    h1    = 1'b0;
    h2    = 1'b0;
    if (in_item.in_exception == EXC_NONE) begin
      case (op)
        OPC_LUI, OPC_AUIPC: begin
          wr  = 1'b1;
          imm = {i[31:12], 12'h000};
        end
        OPC_JAL: begin
          wr  = 1'b1;
          imm = {{11{i[31]}}, i[31], i[19:12], i[20], i[30:21], 1'b0};
        end
        OPC_JALR: begin
          use1  = 1'b1;
          wr    = 1'b1;
          imm   = {{20{i[31]}}, i[31:20]};
          legal = (f3 == 3'd0);
        end
        OPC_BRANCH: begin
          use1  = 1'b1;
          use2  = 1'b1;
          imm   = {{19{i[31]}}, i[31], i[7], i[30:25], i[11:8], 1'b0};
          legal = !(f3 inside {3'd2, 3'd3});
        end
        OPC_LOAD: begin
          use1  = 1'b1;
          wr    = 1'b1;
          imm   = {{20{i[31]}}, i[31:20]};
          legal = f3 inside {3'd0, 3'd1, 3'd2, 3'd4, 3'd5};
        end
        OPC_STORE: begin
          use1  = 1'b1;
          use2  = 1'b1;
          imm   = {{20{i[31]}}, i[31:25], i[11:7]};
          legal = (f3 <= 3'd2);
        end
        OPC_OPIMM: begin
          use1 = 1'b1;
          wr   = 1'b1;
          imm  = {{20{i[31]}}, i[31:20]};
          if (f3 == 3'd1) begin
            legal = (f7 == F7_BASE);
          end
          if (f3 == 3'd5) begin
            legal = (f7 == F7_BASE) || (f7 == F7_ALT);
          end
        end
        OPC_OP: begin
          use1  = 1'b1;
          use2  = 1'b1;
          wr    = 1'b1;
          legal = (f7 == F7_BASE) || (f7 == F7_MUL) ||
                  ((f7 == F7_ALT) && (f3 inside {3'd0, 3'd5}));
        end
        OPC_AMO: begin
          use1 = 1'b1;
          use2 = 1'b1;
          wr   = 1'b1;
          if (i[31:27] == AMO_LR) begin
            use2  = 1'b0;
            legal = (f3 == 3'd2) && (rs2 == 5'd0);
          end else if (i[31:27] inside {5'h00, 5'h01, 5'h03, 5'h04, 5'h08,
                                        5'h0c, 5'h10, 5'h14, 5'h18, 5'h1c}) begin
            legal = (f3 == 3'd2);
          end else begin
            legal = 1'b0;
          end
        end
        OPC_MISCMEM: begin
          legal = (f3 == 3'd0);
        end
        OPC_SYSTEM: begin
          if (f3 == 3'd0) begin
            if (i == WORD_ECALL) begin
              exc = EXC_ECALL;
            end else if (i == WORD_EBREAK) begin
              exc = EXC_BREAK;
            end else begin
              legal = 1'b0;
            end
            tval = (i == WORD_EBREAK) ? in_item.pc : 32'h0;
          end else if (f3 != 3'd4) begin
            csr  = i[31:20];
            wr   = 1'b1;
            use1 = (f3 <= 3'd3);
          end else begin
            legal = 1'b0;
          end
        end
        default: begin
          legal = 1'b0;
        end
      endcase
      if (!legal) begin
        exc  = EXC_ILLEGAL;
        tval = i;
      end
      if (exc == EXC_NONE) begin
        // register zero never waits on a pending write
        h1 = use1 && (rs1 != 5'd0) &&
             ((in_item.ex_valid && in_item.ex_writes_rd && in_item.ex_rd == rs1) ||
              (in_item.mem_valid && in_item.mem_writes_rd && in_item.mem_rd == rs1));
        h2 = use2 && (rs2 != 5'd0) &&
             ((in_item.ex_valid && in_item.ex_writes_rd && in_item.ex_rd == rs2) ||
              (in_item.mem_valid && in_item.mem_writes_rd && in_item.mem_rd == rs2));
        tval = 32'h0;
      end
    end
  end

  always_comb begin
    dec                = '0;
    dec.stall_res      = h1 || h2;
    dec.dest_reg       = i[11:7];
    dec.src1_reg       = rs1;
    dec.src2_reg       = rs2;
    dec.writes_dest    = wr;
    dec.immediate      = imm;
    dec.csr_number     = csr;
    dec.exception_code = exc;
    dec.trap_value     = tval;
  end

endmodule

### rtl/rvdec_port_check.sv
// Port-level checks for the RV32IMA decode stage, bound to the top level.
// Uses the result beat layout from rvdec_pkg.
module rvdec_port_check
  import rvdec_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [IN_BITS-1:0]  s_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OUT_BITS-1:0] m_axis_tdata
);

  out_item_t res;
  assign res = out_item_t'(m_axis_tdata);

  // A held output beat stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // Nothing comes out the cycle after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  // A hazard stall only goes with a clean, exception-free beat
  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.stall_res |->
      res.exception_code == EXC_NONE && res.trap_value == 32'h0)
    else $error("stall raised alongside an exception");

  // No exception means no trap value
  a_tval: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.exception_code == EXC_NONE |-> res.trap_value == 32'h0)
    else $error("trap value without exception");

  // Input side: an unaccepted beat stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("input beat withdrawn while stalled");

endmodule

bind rv32ima_decode_with_hazard_stall rvdec_port_check u_port_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### test/testbench.sv
// Self-checking bench for rv32ima_decode_with_hazard_stall: a table of directed words,
// then random instruction streams with EX/MEM hazards, checked against a local decoder.
// Depends on rvdec_pkg and the top level only.
module testbench;
  import rvdec_pkg::*;

  // AMO funct5 codes accepted besides load-reserved
  localparam logic [4:0] AMO_ADD  = 5'h00;
  localparam logic [4:0] AMO_SWAP = 5'h01;
  localparam logic [4:0] AMO_SC   = 5'h03;
  localparam logic [4:0] AMO_XOR  = 5'h04;
  localparam logic [4:0] AMO_OR   = 5'h08;
  localparam logic [4:0] AMO_AND  = 5'h0c;
  localparam logic [4:0] AMO_MIN  = 5'h10;
  localparam logic [4:0] AMO_MAX  = 5'h14;
  localparam logic [4:0] AMO_MINU = 5'h18;
  localparam logic [4:0] AMO_MAXU = 5'h1c;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN       = 8;

  typedef struct packed {
    in_item_t  stim;
    logic      typed;
    out_item_t want;
  } row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_BITS-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0] m_axis_tdata;

  out_item_t decodes_in_flight[$];
  row_t      rows[$];
  out_item_t got, want;
  int        fails = 0;
  int        cycles = 0;
  int        src_idle = 37;
  int        sink_idle = 73;

  rv32ima_decode_with_hazard_stall DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bit reg_pending(input logic v, input logic w, input logic [4:0] rd,
                                     input logic [4:0] r);
    return r != 5'd0 && v && w && rd == r;
  endfunction

  function automatic out_item_t decode_word(input in_item_t it);
    out_item_t   r;
    logic [31:0] w;
    logic [6:0]  f7;
    logic [2:0]  f3;
    logic [4:0]  exc;
    logic [31:0] tv;
    bit          use1, use2, ok, h1, h2;
    w = it.insn;
    f7 = w[31:25];
    f3 = w[14:12];
    r = '0;
    r.dest_reg = w[11:7];
    r.src1_reg = w[19:15];
    r.src2_reg = w[24:20];
    exc = it.in_exception;
    tv = it.in_tval;
    use1 = 0;
    use2 = 0;
    ok = 1;
    if (exc == EXC_NONE) begin
      case (w[6:0])
        OPC_LUI, OPC_AUIPC: begin
          r.writes_dest = 1'b1;
          r.immediate = {w[31:12], 12'h000};
        end
        OPC_JAL: begin
          r.writes_dest = 1'b1;
          r.immediate = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
        end
        OPC_JALR: begin
          use1 = 1;
          r.writes_dest = 1'b1;
          r.immediate = {{20{w[31]}}, w[31:20]};
          ok = f3 == 3'd0;
        end
        OPC_BRANCH: begin
          use1 = 1;
          use2 = 1;
          r.immediate = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
          ok = f3 != 3'd2 && f3 != 3'd3;
        end
        OPC_LOAD: begin
          use1 = 1;
          r.writes_dest = 1'b1;
          r.immediate = {{20{w[31]}}, w[31:20]};
          ok = f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2 || f3 == 3'd4 || f3 == 3'd5;
        end
        OPC_STORE: begin
          use1 = 1;
          use2 = 1;
          r.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
          ok = f3 <= 3'd2;
        end
        OPC_OPIMM: begin
          use1 = 1;
          r.writes_dest = 1'b1;
          r.immediate = {{20{w[31]}}, w[31:20]};
          // shifts restrict funct7
          if (f3 == 3'd1) ok = f7 == F7_BASE;
          if (f3 == 3'd5) ok = f7 == F7_BASE || f7 == F7_ALT;
        end
        OPC_OP: begin
          use1 = 1;
          use2 = 1;
          r.writes_dest = 1'b1;
          ok = f7 == F7_BASE || f7 == F7_MUL ||
               (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5));
        end
        OPC_AMO: begin
          use1 = 1;
          use2 = 1;
          r.writes_dest = 1'b1;
          case (w[31:27])
            AMO_LR: begin
              use2 = 0;
              ok = f3 == 3'd2 && w[24:20] == 5'd0;
            end
            AMO_ADD, AMO_SWAP, AMO_SC, AMO_XOR, AMO_OR, AMO_AND,
            AMO_MIN, AMO_MAX, AMO_MINU, AMO_MAXU: ok = f3 == 3'd2;
            default: ok = 0;
          endcase
        end
        OPC_MISCMEM: ok = f3 == 3'd0;
        OPC_SYSTEM: begin
          if (f3 == 3'd0) begin
            if (w == WORD_ECALL) exc = EXC_ECALL;
            else if (w == WORD_EBREAK) exc = EXC_BREAK;
            else ok = 0;
            tv = (w == WORD_EBREAK) ? it.pc : 32'd0;
          end else if (f3 != 3'd4) begin
            r.csr_number = w[31:20];
            r.writes_dest = 1'b1;
            use1 = f3 <= 3'd3;
          end else begin
            ok = 0;
          end
        end
        default: ok = 0;
      endcase
      if (!ok) begin
        exc = EXC_ILLEGAL;
        tv = w;
      end
      if (exc == EXC_NONE) begin
        h1 = use1 && (reg_pending(it.ex_valid, it.ex_writes_rd, it.ex_rd, w[19:15]) ||
                      reg_pending(it.mem_valid, it.mem_writes_rd, it.mem_rd, w[19:15]));
        h2 = use2 && (reg_pending(it.ex_valid, it.ex_writes_rd, it.ex_rd, w[24:20]) ||
                      reg_pending(it.mem_valid, it.mem_writes_rd, it.mem_rd, w[24:20]));
        r.stall_res = h1 || h2;
        tv = 32'd0;
      end
    end
    r.exception_code = exc;
    r.trap_value = tv;
    return r;
  endfunction

  function automatic in_item_t beat_of(input logic [31:0] insn, input logic [31:0] pc,
                                       input logic [4:0] exc, input logic [31:0] tval,
                                       input logic exv, input logic exw, input logic [4:0] exrd,
                                       input logic mv, input logic mw, input logic [4:0] mrd);
    in_item_t it;
    it = '0;
    it.insn = insn;
    it.pc = pc;
    it.in_exception = exc;
    it.in_tval = tval;
    it.ex_valid = exv;
    it.ex_writes_rd = exw;
    it.ex_rd = exrd;
    it.mem_valid = mv;
    it.mem_writes_rd = mw;
    it.mem_rd = mrd;
    return it;
  endfunction

  function automatic out_item_t result_of(input logic [4:0] rd, input logic [4:0] rs1,
                                          input logic [4:0] rs2, input logic [4:0] exc,
                                          input logic [31:0] tval);
    out_item_t r;
    r = '0;
    r.dest_reg = rd;
    r.src1_reg = rs1;
    r.src2_reg = rs2;
    r.exception_code = exc;
    r.trap_value = tval;
    return r;
  endfunction

  task automatic add_row(input in_item_t stim, input logic typed, input out_item_t w);
    row_t row;
    row.stim = stim;
    row.typed = typed;
    row.want = w;
    rows.push_back(row);
  endtask

  function automatic in_item_t random_beat();
    in_item_t    it;
    logic [31:0] w;
    logic [2:0]  f3;
    logic [4:0]  f5;
    bit          fix;
    w = $urandom;
    fix = $urandom_range(99) < 85;
    // a few raw words stay as noise
    if ($urandom_range(99) >= 8) begin
      case ($urandom_range(11))
        0: w[6:0] = OPC_LUI;
        1: w[6:0] = OPC_AUIPC;
        2: w[6:0] = OPC_JAL;
        3: begin
          w[6:0] = OPC_JALR;
          if (fix) w[14:12] = 3'd0;
        end
        4: begin
          w[6:0] = OPC_BRANCH;
          f3 = 3'($urandom_range(5));
          if (f3 >= 3'd2) f3 = f3 + 3'd2;
          if (fix) w[14:12] = f3;
        end
        5: begin
          w[6:0] = OPC_LOAD;
          f3 = 3'($urandom_range(4));
          if (f3 >= 3'd3) f3 = f3 + 3'd1;
          if (fix) w[14:12] = f3;
        end
        6: begin
          w[6:0] = OPC_STORE;
          if (fix) w[14:12] = 3'($urandom_range(2));
        end
        7: begin
          w[6:0] = OPC_OPIMM;
          if (fix && w[14:12] == 3'd1) w[31:25] = F7_BASE;
          if (fix && w[14:12] == 3'd5) w[31:25] = $urandom_range(1) ? F7_ALT : F7_BASE;
        end
        8: begin
          w[6:0] = OPC_OP;
          if (fix) begin
            case ($urandom_range(2))
              0: w[31:25] = F7_BASE;
              1: w[31:25] = F7_MUL;
              default: begin
                w[31:25] = F7_ALT;
                w[14:12] = $urandom_range(1) ? 3'd5 : 3'd0;
              end
            endcase
          end
        end
        9: begin
          w[6:0] = OPC_AMO;
          case ($urandom_range(10))
            0: f5 = AMO_LR;
            1: f5 = AMO_ADD;
            2: f5 = AMO_SWAP;
            3: f5 = AMO_SC;
            4: f5 = AMO_XOR;
            5: f5 = AMO_OR;
            6: f5 = AMO_AND;
            7: f5 = AMO_MIN;
            8: f5 = AMO_MAX;
            9: f5 = AMO_MINU;
            default: f5 = AMO_MAXU;
          endcase
          if (fix) begin
            w[31:27] = f5;
            w[14:12] = 3'd2;
            if (f5 == AMO_LR) w[24:20] = 5'd0;
          end
        end
        10: begin
          w[6:0] = OPC_MISCMEM;
          if (fix) w[14:12] = 3'd0;
        end
        default: begin
          w[6:0] = OPC_SYSTEM;
          f3 = 3'($urandom_range(5));
          if (f3 >= 3'd3) f3 = f3 + 3'd2;
          else f3 = f3 + 3'd1;
          if (fix) w[14:12] = f3;
          case ($urandom_range(9))
            0: w = WORD_ECALL;
            1: w = WORD_EBREAK;
            default: ;
          endcase
        end
      endcase
    end
    it = beat_of(w, $urandom, 5'd0, $urandom,
                 $urandom_range(3) != 0, $urandom_range(3) != 0, 5'($urandom),
                 $urandom_range(3) != 0, $urandom_range(3) != 0, 5'($urandom));
    // aim the pending destinations at the sources most of the time
    case ($urandom_range(2))
      0: it.ex_rd = w[19:15];
      1: it.ex_rd = w[24:20];
      default: ;
    endcase
    case ($urandom_range(2))
      0: it.mem_rd = w[24:20];
      1: it.mem_rd = w[19:15];
      default: ;
    endcase
    if ($urandom_range(9) == 0) it.in_exception = 5'($urandom_range(31, 1));
    return it;
  endfunction

  // One input beat: optional idle cycles, then hold until accepted.
  task automatic send_beat(input in_item_t it, input logic typed, input out_item_t w);
    bit taken;
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= it;
    do begin
      @(negedge clk);
      taken = s_axis_tready;
      @(posedge clk);
    end while (!taken);
    decodes_in_flight.push_back(typed ? w : decode_word(it));
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    m_axis_tready <= $urandom_range(99) >= sink_idle;
  end

  // Outputs change only at the rising edge; sample the beat mid-cycle.
  always @(negedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      got = m_axis_tdata;
      if (decodes_in_flight.size() == 0) begin
        $error("decode result with nothing pending: %h", m_axis_tdata);
        fails++;
      end else begin
        want = decodes_in_flight.pop_front();
        check_field("stall_res", 32'(want.stall_res), 32'(got.stall_res));
        check_field("dest_reg", 32'(want.dest_reg), 32'(got.dest_reg));
        check_field("src1_reg", 32'(want.src1_reg), 32'(got.src1_reg));
        check_field("src2_reg", 32'(want.src2_reg), 32'(got.src2_reg));
        check_field("writes_dest", 32'(want.writes_dest), 32'(got.writes_dest));
        check_field("immediate", want.immediate, got.immediate);
        check_field("csr_number", 32'(want.csr_number), 32'(got.csr_number));
        check_field("exception_code", 32'(want.exception_code),
                    32'(got.exception_code));
        check_field("trap_value", want.trap_value, got.trap_value);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    // words whose result is plain to see
    add_row(beat_of(WORD_ECALL, 32'h0000_1234, EXC_NONE, 32'hffff_ffff,
                    1, 1, 5'd0, 1, 1, 5'd0), 1,
            result_of(5'd0, 5'd0, 5'd0, EXC_ECALL, 32'd0));
    add_row(beat_of(WORD_EBREAK, 32'hffff_fffc, EXC_NONE, 32'h0,
                    1, 1, 5'd1, 1, 1, 5'd1), 1,
            result_of(5'd0, 5'd0, 5'd1, EXC_BREAK, 32'hffff_fffc));
    add_row(beat_of(32'h0000_0000, 32'h0, EXC_NONE, 32'h0, 0, 0, 5'd0, 0, 0, 5'd0), 1,
            result_of(5'd0, 5'd0, 5'd0, EXC_ILLEGAL, 32'h0));
    add_row(beat_of(32'hffff_ffff, 32'hffff_ffff, EXC_NONE, 32'hffff_ffff,
                    1, 1, 5'd31, 1, 1, 5'd31), 1,
            result_of(5'd31, 5'd31, 5'd31, EXC_ILLEGAL, 32'hffff_ffff));
    add_row(beat_of(32'hffff_ffff, 32'h0, 5'd16, 32'hdead_beef, 1, 1, 5'd31, 1, 1, 5'd31), 1,
            result_of(5'd31, 5'd31, 5'd31, 5'd16, 32'hdead_beef));
    add_row(beat_of(32'h0000_0013, 32'h0, 5'd31, 32'hffff_ffff, 0, 0, 5'd0, 0, 0, 5'd0), 1,
            result_of(5'd0, 5'd0, 5'd0, 5'd31, 32'hffff_ffff));
    // one of each format, hazard on and off
    add_row(beat_of(32'hffff_f2b7, 32'h0, EXC_NONE, 32'h0, 1, 1, 5'd5, 0, 0, 5'd0), 0, '0);
    add_row(beat_of(32'h8000_0097, 32'h0, EXC_NONE, 32'h0, 0, 0, 5'd0, 0, 0, 5'd0), 0, '0);
    add_row(beat_of(32'h8000_00ef, 32'h0, EXC_NONE, 32'h0, 0, 0, 5'd0, 0, 0, 5'd0), 0, '0);
    add_row(beat_of(32'hfff1_00e7, 32'h0, EXC_NONE, 32'h0, 1, 1, 5'd2, 0, 0, 5'd0), 0, '0);
    add_row(beat_of(32'h0001_10e7, 32'h0, EXC_NONE, 32'h0, 1, 1, 5'd2, 0, 0, 5'd0), 0, '0);
    add_row(beat_of(32'h0041_8463, 32'h0, EXC_NONE, 32'h0, 0, 0, 5'd0, 1, 1, 5'd4), 0, '0);
    add_row(beat_of(32'h8000_2283, 32'h0, EXC_NONE, 32'h0, 1, 1, 5'd0, 1, 1, 5'd0), 0, '0);
    add_row(beat_of(32'hffff_afa3, 32'h0, EXC_NONE, 32'h0, 1, 0, 5'd31, 0, 1, 5'd31), 0, '0);
    add_row(beat_of(32'h4031_5093, 32'h0, EXC_NONE, 32'h0, 1, 1, 5'd2, 1, 1, 5'd2), 0, '0);
    add_row(beat_of(32'h0231_1093, 32'h0, EXC_NONE, 32'h0, 0, 0, 5'd0, 0, 0, 5'd0), 0, '0);
    add_row(beat_of(32'h0252_01b3, 32'h0, EXC_NONE, 32'h0, 1, 1, 5'd5, 0, 0, 5'd0), 0, '0);
    add_row(beat_of(32'h4052_1133, 32'h0, EXC_NONE, 32'h0, 1, 1, 5'd5, 0, 0, 5'd0), 0, '0);
    add_row(beat_of(32'h1001_20af, 32'h0, EXC_NONE, 32'h0, 0, 0, 5'd0, 1, 1, 5'd0), 0, '0);
    add_row(beat_of(32'h1011_20af, 32'h0, EXC_NONE, 32'h0, 1, 1, 5'd1, 0, 0, 5'd0), 0, '0);
    add_row(beat_of(32'he031_20af, 32'h0, EXC_NONE, 32'h0, 0, 0, 5'd0, 1, 1, 5'd3), 0, '0);
    add_row(beat_of(32'h0ff0_000f, 32'h0, EXC_NONE, 32'h0, 0, 0, 5'd0, 0, 0, 5'd0), 0, '0);
    add_row(beat_of(32'hfff1_10f3, 32'h0, EXC_NONE, 32'h0, 1, 1, 5'd2, 0, 0, 5'd0), 0, '0);
    add_row(beat_of(32'hfff1_50f3, 32'h0, EXC_NONE, 32'h0, 1, 1, 5'd2, 1, 1, 5'd2), 0, '0);
    add_row(beat_of(32'h3020_0073, 32'h8000_0000, EXC_NONE, 32'h0,
                    0, 0, 5'd0, 0, 0, 5'd0), 0, '0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[k]) send_beat(rows[k].stim, rows[k].typed, rows[k].want);

    for (int n = 0; n < 2000; n++) begin
      if (n == 667) begin
        src_idle = 73;
        sink_idle = 37;
      end
      if (n == 1334) begin
        src_idle = 0;
        sink_idle = 0;
      end
      send_beat(random_beat(), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    wait (decodes_in_flight.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (fails == 0 && decodes_in_flight.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
